>>> rtl/core/msl_pkg.sv
`default_nettype none
package msl_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int MAX_CHUNKS  = 1024;
  localparam int MAX_RUNS    = 64;

  localparam int SIDX_W = $clog2(MAX_SAMPLES);
  localparam int CIDX_W = $clog2(MAX_CHUNKS);
  localparam int RIDX_W = $clog2(MAX_RUNS);

  // input command codes
  localparam logic [1:0] CMD_LOAD_RUN   = 2'd0;
  localparam logic [1:0] CMD_LOAD_SIZE  = 2'd1;
  localparam logic [1:0] CMD_LOAD_CHUNK = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  // result error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_CHUNK_COUNT  = 2'd0;
  localparam logic [1:0] CFG_RUN_COUNT    = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

  typedef struct packed {
    logic accept;    // item taken this cycle
    logic init_rd;   // read run entry 0
    logic init_cap;  // capture run entry 0
    logic run_adv;   // step to next run
    logic chunk_step;
    logic off_rd;    // read chunk offset and sample size
    logic off_cap;
    logic sum_add;
    logic out_ok;
    logic out_fail;
  } msl_cmd_t;

  typedef struct packed {
    logic q_bad;
    logic nxt_avail;
    logic nxt_le;
    logic hit;
    logic last_chunk;
    logic sum_done;
    logic out_free;
  } msl_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/msl_ctrl.sv
`default_nettype none
module msl_ctrl
  import msl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  input  wire msl_sts_t   sts,
  output msl_cmd_t        cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'h001,
    S_INIT_RD  = 12'h002,
    S_INIT_CAP = 12'h004,
    S_RUN_RD   = 12'h008,
    S_RUN_CHK  = 12'h010,
    S_CHUNK    = 12'h020,
    S_OFF_RD   = 12'h040,
    S_OFF_CAP  = 12'h080,
    S_SUM_RD   = 12'h100,
    S_SUM_ADD  = 12'h200,
    S_FAIL     = 12'h400,
    S_DONE     = 12'h800
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_QUERY) state_nxt = S_INIT_RD;
        end
      end
      S_INIT_RD: begin
        cmd.init_rd = 1'b1;
        state_nxt   = sts.q_bad ? S_FAIL : S_INIT_CAP;
      end
      S_INIT_CAP: begin
        cmd.init_cap = 1'b1;
        state_nxt    = S_RUN_RD;
      end
      S_RUN_RD: state_nxt = sts.nxt_avail ? S_RUN_CHK : S_CHUNK;
      S_RUN_CHK: begin
        if (sts.nxt_le) begin
          cmd.run_adv = 1'b1;
          state_nxt   = S_RUN_RD;
        end else begin
          state_nxt = S_CHUNK;
        end
      end
      S_CHUNK: begin
        if (sts.hit) begin
          state_nxt = S_OFF_RD;
        end else if (sts.last_chunk) begin
          state_nxt = S_FAIL;
        end else begin
          cmd.chunk_step = 1'b1;
          state_nxt      = S_RUN_RD;
        end
      end
      S_OFF_RD: begin
        cmd.off_rd = 1'b1;
        state_nxt  = S_OFF_CAP;
      end
      S_OFF_CAP: begin
        cmd.off_cap = 1'b1;
        state_nxt   = S_SUM_RD;
      end
      S_SUM_RD: state_nxt = sts.sum_done ? S_DONE : S_SUM_ADD;
      S_SUM_ADD: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_SUM_RD;
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.out_fail = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ok = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/msl_dp.sv
`default_nettype none
module msl_dp
  import msl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic [1:0]  in_command,
  input  wire logic [11:0] in_entry_index,
  input  wire logic [10:0] in_run_first_chunk,
  input  wire logic [12:0] in_run_samples_per_chunk,
  input  wire logic [31:0] in_table_value,
  input  wire logic [11:0] in_query_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sample_offset,
  output logic [31:0]      out_sample_bytes,
  output logic [1:0]       out_error_code,
  input  wire msl_cmd_t    cmd,
  output msl_sts_t         sts
);

  logic [10:0] chunk_count_r;
  logic [6:0]  run_count_r;
  logic [12:0] sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_count_r  <= '0;
      run_count_r    <= '0;
      sample_count_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_CHUNK_COUNT:  chunk_count_r  <= cfg_data[10:0];
        CFG_RUN_COUNT:    run_count_r    <= cfg_data[6:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [10:0] nch;
  logic [6:0]  nrun;
  logic [12:0] nsmp;
  assign nch  = (chunk_count_r > 11'(MAX_CHUNKS)) ? 11'(MAX_CHUNKS) : chunk_count_r;
  assign nrun = (run_count_r > 7'(MAX_RUNS)) ? 7'(MAX_RUNS) : run_count_r;
  assign nsmp = (sample_count_r > 13'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES) : sample_count_r;

  // walk state
  logic [SIDX_W-1:0] s_r, first_r, i_r;
  logic [RIDX_W-1:0] run_r;
  logic [10:0]       c_r, cur_first_r;
  logic [12:0]       cur_spc_r;
  logic [31:0]       pos_r, bytes_r;
  logic              ovf_r;

  logic load;
  assign load = cmd.accept && (in_command != CMD_QUERY);

  // tables
  logic [31:0] size_mem  [MAX_SAMPLES];
  logic [31:0] chunk_mem [MAX_CHUNKS];
  logic [10:0] rfirst_mem [MAX_RUNS];
  logic [12:0] rspc_mem   [MAX_RUNS];

  logic [31:0] size_rd_r, chunk_rd_r;
  logic [10:0] rfirst_rd_r;
  logic [12:0] rspc_rd_r;

  logic [RIDX_W:0]   run_p1;
  logic [RIDX_W-1:0] run_addr;
  logic [10:0]       cm1;
  logic [SIDX_W-1:0] size_addr;

  assign run_p1    = {1'b0, run_r} + (RIDX_W+1)'(1);
  assign run_addr  = cmd.init_rd ? '0 : run_p1[RIDX_W-1:0];
  assign cm1       = c_r - 11'd1;
  assign size_addr = cmd.off_rd ? s_r : i_r;

  always_ff @(posedge clk) begin
    if (load && in_command == CMD_LOAD_SIZE)
      size_mem[in_entry_index[SIDX_W-1:0]] <= in_table_value;
    size_rd_r <= size_mem[size_addr];
  end

  always_ff @(posedge clk) begin
    if (load && in_command == CMD_LOAD_CHUNK && in_entry_index < 12'(MAX_CHUNKS))
      chunk_mem[in_entry_index[CIDX_W-1:0]] <= in_table_value;
    chunk_rd_r <= chunk_mem[cm1[CIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load && in_command == CMD_LOAD_RUN && in_entry_index < 12'(MAX_RUNS)) begin
      rfirst_mem[in_entry_index[RIDX_W-1:0]] <= in_run_first_chunk;
      rspc_mem[in_entry_index[RIDX_W-1:0]]   <= in_run_samples_per_chunk;
    end
    rfirst_rd_r <= rfirst_mem[run_addr];
    rspc_rd_r   <= rspc_mem[run_addr];
  end

  logic [12:0] spc_eff;
  logic [13:0] first_end;
  logic [32:0] sum33;
  assign spc_eff   = (cur_first_r <= c_r) ? cur_spc_r : 13'd0;
  assign first_end = {2'b0, first_r} + {1'b0, spc_eff};
  assign sum33     = {1'b0, pos_r} + {1'b0, size_rd_r};

  always_ff @(posedge clk) begin
    if (cmd.accept && in_command == CMD_QUERY) begin
      s_r     <= in_query_sample;
      run_r   <= '0;
      c_r     <= 11'd1;
      first_r <= '0;
      ovf_r   <= 1'b0;
    end
    if (cmd.init_cap) begin
      cur_first_r <= rfirst_rd_r;
      cur_spc_r   <= rspc_rd_r;
    end
    if (cmd.run_adv) begin
      cur_first_r <= rfirst_rd_r;
      cur_spc_r   <= rspc_rd_r;
      run_r       <= run_p1[RIDX_W-1:0];
    end
    if (cmd.chunk_step) begin
      first_r <= first_end[SIDX_W-1:0];  // stays at or below the query index
      c_r     <= c_r + 11'd1;
    end
    if (cmd.off_cap) begin
      pos_r   <= chunk_rd_r;
      bytes_r <= size_rd_r;
      i_r     <= first_r;
    end
    if (cmd.sum_add) begin
      pos_r <= sum33[31:0];
      ovf_r <= ovf_r | sum33[32];
      i_r   <= i_r + SIDX_W'(1);
    end
  end

  logic out_valid_r;
  logic [31:0] off_out_r, bytes_out_r;
  logic [1:0]  err_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ok || cmd.out_fail) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fail) begin
      off_out_r   <= '0;
      bytes_out_r <= '0;
      err_out_r   <= ERR_RANGE;
    end else if (cmd.out_ok) begin
      off_out_r   <= ovf_r ? 32'd0 : pos_r;
      bytes_out_r <= bytes_r;
      err_out_r   <= ovf_r ? ERR_OVF : ERR_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_offset = off_out_r;
  assign out_sample_bytes  = bytes_out_r;
  assign out_error_code    = err_out_r;

  assign sts.q_bad      = ({1'b0, s_r} >= nsmp) || (nrun == '0) || (nch == '0);
  assign sts.nxt_avail  = run_p1 < nrun;
  assign sts.nxt_le     = rfirst_rd_r <= c_r;
  assign sts.hit        = {2'b0, s_r} < first_end;
  assign sts.last_chunk = c_r >= nch;
  assign sts.sum_done   = i_r == s_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_ok || cmd.out_fail) |-> (!out_valid_r || out_ready))
    else $error("result written over a pending one");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_add |-> (i_r < s_r))
    else $error("size sum ran past the query index");

  a_ovf_code: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_ok && ovf_r) |=> (out_error_code == ERR_OVF && out_sample_offset == 32'd0))
    else $error("overflow not reported");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (err_out_r == ERR_OK || err_out_r == ERR_RANGE || err_out_r == ERR_OVF))
    else $error("bad error code");

endmodule
`default_nettype wire

>>> rtl/core/mp4_sample_locator.sv
// mp4_sample_locator: sample table lookup for MP4 files.
// Input channel (in_valid/in_ready): one item per command. Load items write
//   a run entry, a sample size or a chunk offset; out-of-depth slots are
//   dropped. A query item locates one sample and yields one result item.
// Result channel (out_valid/out_ready): file offset, size and error code.
//   The result sits in an output register, so loads are taken while it waits.
// Config port: cfg_write_en/cfg_index/cfg_data set chunk, run and sample
//   counts; write only while no query is in flight.
// Flow: loads are taken back to back while the block is idle. A query walks
//   the run entries and the chunks, then sums the sizes of the samples
//   before it in its chunk before its result is registered; an index at or
//   past the sample count, or a zero run or chunk count, fails before the
//   walk, a sample no chunk covers once its walk ends. How long a query takes
//   is set by the run/chunk walk and the single read port of the size table.
//   The next item is taken once the result is registered.
// Reset: counts clear to zero, no result pending. Tables are not cleared.
// Stall: a finished query waits in its final state until the output
//   register is free; loads are not taken meanwhile.
`default_nettype none
module mp4_sample_locator
  import msl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [11:0] in_entry_index,
  input  wire logic [10:0] in_run_first_chunk,
  input  wire logic [12:0] in_run_samples_per_chunk,
  input  wire logic [31:0] in_table_value,
  input  wire logic [11:0] in_query_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sample_offset,
  output logic [31:0]      out_sample_bytes,
  output logic [1:0]       out_error_code
);

  msl_cmd_t cmd;
  msl_sts_t sts;

  msl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msl_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_write_en            (cfg_write_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_command              (in_command),
    .in_entry_index          (in_entry_index),
    .in_run_first_chunk      (in_run_first_chunk),
    .in_run_samples_per_chunk(in_run_samples_per_chunk),
    .in_table_value          (in_table_value),
    .in_query_sample         (in_query_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_sample_offset       (out_sample_offset),
    .out_sample_bytes        (out_sample_bytes),
    .out_error_code          (out_error_code),
    .cmd                     (cmd),
    .sts                     (sts)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb;
  import msl_pkg::*;

  // one input item as queued for the driver
  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic [10:0] first_chunk;
    logic [12:0] spc;
    logic [31:0] value;
    logic [11:0] sample;
  } item_t;

  // one located sample
  typedef struct {
    logic [31:0] offset;
    logic [31:0] bytes;
    logic [1:0]  err;
  } loc_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [11:0] in_entry_index;
  logic [10:0] in_run_first_chunk;
  logic [12:0] in_run_samples_per_chunk;
  logic [31:0] in_table_value;
  logic [11:0] in_query_sample;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_sample_offset;
  logic [31:0] out_sample_bytes;
  logic [1:0]  out_error_code;

  mp4_sample_locator u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_write_en            (cfg_write_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_entry_index          (in_entry_index),
    .in_run_first_chunk      (in_run_first_chunk),
    .in_run_samples_per_chunk(in_run_samples_per_chunk),
    .in_table_value          (in_table_value),
    .in_query_sample         (in_query_sample),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_sample_offset       (out_sample_offset),
    .out_sample_bytes        (out_sample_bytes),
    .out_error_code          (out_error_code)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // shadow copy of the tables and counts
  logic [10:0] run_first_sh [MAX_RUNS];
  logic [12:0] run_spc_sh   [MAX_RUNS];
  logic [31:0] size_sh      [MAX_SAMPLES];
  logic [31:0] chunk_off_sh [MAX_CHUNKS];
  logic [10:0] chunk_cnt_sh;
  logic [6:0]  run_cnt_sh;
  logic [12:0] sample_cnt_sh;

  item_t stim_q[$];
  loc_t  loc_q[$];     // expected results, oldest first
  int    n_err;
  int    n_items;
  int    hold_req;     // long receiver hold-off, set by a test

  // Walk the chunks, giving each the samples-per-chunk of the run in force,
  // then sum sizes inside the hit chunk.
  function automatic loc_t locate(logic [11:0] s);
    loc_t r;
    int unsigned nch, nrn, nsm, run, spc;
    longint unsigned first, pos;
    nch = (chunk_cnt_sh < MAX_CHUNKS) ? chunk_cnt_sh : MAX_CHUNKS;
    nrn = (run_cnt_sh < MAX_RUNS) ? run_cnt_sh : MAX_RUNS;
    nsm = (sample_cnt_sh < MAX_SAMPLES) ? sample_cnt_sh : MAX_SAMPLES;
    r.offset = '0;
    r.bytes  = '0;
    r.err    = ERR_RANGE;
    first = 0;
    run   = 0;
    if (s >= nsm || nrn == 0) return r;
    for (int unsigned c = 1; c <= nch; c++) begin
      // unordered runs: skip following runs already started, up to the first not yet started
      while (run + 1 < nrn && run_first_sh[run + 1] <= c) run++;
      // chunks ahead of the first run hold nothing
      spc = (run_first_sh[run] <= c) ? run_spc_sh[run] : 0;
      if (s < first + spc) begin
        pos = chunk_off_sh[c - 1];
        for (longint unsigned i = first; i < s; i++) pos += size_sh[i];
        r.bytes = size_sh[s];
        if (pos > 64'hFFFF_FFFF) begin
          r.err = ERR_OVF;
        end else begin
          r.offset = pos[31:0];
          r.err    = ERR_OK;
        end
        return r;
      end
      first += spc;
    end
    return r;
  endfunction

  // update the shadow tables for an accepted item, queue its result
  function automatic void take_item(item_t it);
    case (it.cmd)
      CMD_LOAD_RUN: begin
        if (it.idx < MAX_RUNS) begin
          run_first_sh[it.idx] = it.first_chunk;
          run_spc_sh[it.idx]   = it.spc;
        end
      end
      CMD_LOAD_SIZE: begin
        if (it.idx < MAX_SAMPLES) size_sh[it.idx] = it.value;
      end
      CMD_LOAD_CHUNK: begin
        if (it.idx < MAX_CHUNKS) chunk_off_sh[it.idx] = it.value;
      end
      default: loc_q.push_back(locate(it.sample));
    endcase
  endfunction

  // ready sampled mid-cycle, so the edge decision is race free
  logic in_ready_s;
  always @(negedge clk) in_ready_s = in_ready;

  // input driver: bursts of random length with random gaps
  item_t cur;
  int    burst_left;
  int    gap_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_s) take_item(cur);
      if (!in_valid || in_ready_s) begin
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 24);
        end
        if (gap_left > 0 || stim_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur = stim_q.pop_front();
          burst_left--;
          in_valid                 <= 1'b1;
          in_command               <= cur.cmd;
          in_entry_index           <= cur.idx;
          in_run_first_chunk       <= cur.first_chunk;
          in_run_samples_per_chunk <= cur.spc;
          in_table_value           <= cur.value;
          in_query_sample          <= cur.sample;
        end
      end
    end
  end

  // receiver: its own stall pattern, plus long hold-offs on request
  int hold_left;
  int rx_cyc;
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cyc >> 7) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 9) == 0);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // result checker, sampled mid-cycle
  always @(negedge clk) begin
    loc_t e;
    if (rst_n && out_valid && out_ready) begin
      if (loc_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result off=%h bytes=%h err=%0d",
                                  out_sample_offset, out_sample_bytes, out_error_code);
      end else begin
        e = loc_q.pop_front();
        if (e.offset !== out_sample_offset || e.bytes !== out_sample_bytes ||
            e.err !== out_error_code) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch exp off=%h bytes=%h err=%0d got off=%h bytes=%h err=%0d",
                     e.offset, e.bytes, e.err,
                     out_sample_offset, out_sample_bytes, out_error_code);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [11:0] idx, logic [10:0] fc,
                           logic [12:0] spc, logic [31:0] val, logic [11:0] smp);
    item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.first_chunk = fc;
    it.spc = spc;
    it.value = val;
    it.sample = smp;
    stim_q.push_back(it);
    n_items++;
  endtask

  task automatic send_query(logic [11:0] smp);
    send_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, smp);
  endtask

  // wait until nothing is queued, offered or expected, then settle
  task automatic drain();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || loc_q.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] ridx, logic [12:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= ridx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (ridx)
      CFG_CHUNK_COUNT: chunk_cnt_sh  = val[10:0];
      CFG_RUN_COUNT:   run_cnt_sh    = val[6:0];
      default:         sample_cnt_sh = val;
    endcase
  endtask

  task automatic set_counts(logic [12:0] nch, logic [12:0] nrn, logic [12:0] nsm);
    drain();
    write_cfg(CFG_CHUNK_COUNT, nch);
    write_cfg(CFG_RUN_COUNT, nrn);
    write_cfg(CFG_SAMPLE_COUNT, nsm);
  endtask

  // counts at reset are zero: every query is out of range
  task automatic test_after_reset();
    send_query(12'd0);
    send_query(12'hFFF);
    drain();
  endtask

  // small hand-built tables covering the named corner cases
  task automatic test_directed();
    set_counts(13'd4, 13'd3, 13'd12);
    // chunk 1 lies before the first run, chunks 2..3 hold 2, chunk 4 holds 4096
    send_item(CMD_LOAD_RUN, 12'd0, 11'd2, 13'd2, '0, '0);
    send_item(CMD_LOAD_RUN, 12'd1, 11'd4, 13'd3, '0, '0);
    send_item(CMD_LOAD_RUN, 12'd2, 11'd3, 13'd4096, '0, '0);  // out of order
    send_item(CMD_LOAD_RUN, 12'hFFF, 11'h7FF, 13'h1FFF, '0, '0);  // dropped
    for (int i = 0; i < 4; i++)
      send_item(CMD_LOAD_CHUNK, i, '0, '0, (i == 3) ? 32'hFFFF_FFF0 : i * 1000, '0);
    send_item(CMD_LOAD_CHUNK, 12'hFFF, '0, '0, 32'hFFFF_FFFF, '0);  // dropped
    for (int i = 0; i < 12; i++)
      send_item(CMD_LOAD_SIZE, i, '0, '0, (i >= 4) ? 32'hFFFF_FFFF : i + 7, '0);
    for (int s = 0; s < 8; s++) send_query(s);
    send_query(12'd12);
    // first chunk of zero acts like one
    drain();
    send_item(CMD_LOAD_RUN, 12'd0, 11'd0, 13'd1, '0, '0);
    send_query(12'd0);
    send_query(12'd2);
    drain();
  endtask

  // random tables, mostly well formed, with random queries and load noise
  task automatic test_random_tables();
    int nch, nrn, nsm, r, prev;
    r = 0;
    while (n_items < 400) begin
      nch = $urandom_range(1, 8);
      nrn = $urandom_range(1, 4);
      nsm = $urandom_range(1, 40);
      set_counts(13'(nch), 13'(nrn), 13'(nsm));
      prev = $urandom_range(0, 2);
      for (int i = 0; i < nrn; i++) begin
        if ($urandom_range(0, 9) == 0) prev = $urandom_range(0, 2047);
        else if (i > 0) prev = prev + $urandom_range(0, 3);
        send_item(CMD_LOAD_RUN, i, prev, ($urandom_range(0, 15) == 0) ?
                  $urandom_range(0, 8191) : $urandom_range(0, 8), '0, '0);
      end
      for (int i = 0; i < nch; i++)
        send_item(CMD_LOAD_CHUNK, i, '0, '0, ($urandom_range(0, 5) == 0) ?
                  $urandom : $urandom_range(0, 100000), '0);
      for (int i = 0; i < nsm; i++)
        send_item(CMD_LOAD_SIZE, i, '0, '0, ($urandom_range(0, 7) == 0) ?
                  $urandom : $urandom_range(0, 4000), '0);
      // the receiver sits out a long stretch so the block backs up
      if (r == 2) hold_req = 400;
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(0, 5))
          0: send_item(CMD_LOAD_RUN, $urandom_range(MAX_RUNS, 4095), $urandom,
                       $urandom, $urandom, $urandom);
          1: send_item(CMD_LOAD_CHUNK, $urandom_range(MAX_CHUNKS, 4095), $urandom,
                       $urandom, $urandom, $urandom);
          2: send_query($urandom);
          default: send_query($urandom_range(0, nsm + 2));
        endcase
      end
      r++;
    end
    drain();
  endtask

  // register values past the table depths; every run starts at chunk 1 with
  // 4 samples per chunk, and only the entries the queries touch are loaded
  task automatic test_full_tables();
    set_counts(13'h1FFF, 13'h1FFF, 13'h1FFF);
    for (int i = 0; i < MAX_RUNS; i++)
      send_item(CMD_LOAD_RUN, i, 11'd1, 13'd4, '0, '0);
    send_item(CMD_LOAD_CHUNK, 12'd0, '0, '0, 32'd0, '0);
    send_item(CMD_LOAD_CHUNK, 12'd511, '0, '0, 32'd32704, '0);
    send_item(CMD_LOAD_CHUNK, 12'd1023, '0, '0, 32'd65472, '0);
    for (int i = 0; i < 4; i++) begin
      send_item(CMD_LOAD_SIZE, 12'(i), '0, '0, 32'($urandom_range(0, 31)), '0);
      send_item(CMD_LOAD_SIZE, 12'(2044 + i), '0, '0, 32'($urandom_range(0, 31)), '0);
      send_item(CMD_LOAD_SIZE, 12'(4092 + i), '0, '0, 32'($urandom_range(0, 31)), '0);
    end
    send_query(12'd0);
    send_query(12'd2047);
    send_query(12'hFFF);
    drain();
    set_counts(13'd0, 13'd0, 13'd0);
    send_query(12'd5);
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_CHUNK_COUNT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_command   = CMD_LOAD_RUN;
    in_entry_index           = '0;
    in_run_first_chunk       = '0;
    in_run_samples_per_chunk = '0;
    in_table_value           = '0;
    in_query_sample          = '0;
    out_ready    = 1'b0;
    n_err = 0;
    n_items = 0;
    hold_req = 0;
    hold_left = 0;
    rx_cyc = 0;
    burst_left = 0;
    gap_left = 0;
    chunk_cnt_sh = '0;
    run_cnt_sh = '0;
    sample_cnt_sh = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_directed();
    test_random_tables();
    test_full_tables();

    repeat (50) @(posedge clk);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/core/msl_pkg.sv
rtl/core/msl_ctrl.sv
rtl/core/msl_dp.sv
rtl/core/mp4_sample_locator.sv
dv/tb.sv
